@@ hdl/pprc_pkg.sv @@
package pprc_pkg;

  localparam int unsigned MAX_FRAME = 4096;
  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 2);
  localparam logic [CNT_W-1:0] MAX_FRAME_C = CNT_W'(MAX_FRAME);

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ACFC = 1'd1;

  localparam logic [15:0] FCS_POLY = 16'h8408;
  localparam logic [15:0] FCS_INIT = 16'hffff;
  localparam logic [15:0] FCS_GOOD = 16'hf0b8;
  localparam logic [7:0] ADDR_BYTE = 8'hff;
  localparam logic [7:0] CTRL_BYTE = 8'h03;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_FCS   = 3'd1,
    STATUS_TOO_SHORT = 3'd2,
    STATUS_BAD_ADDR  = 3'd3,
    STATUS_BAD_CTRL  = 3'd4,
    STATUS_OVERSIZE  = 3'd5
  } status_e;

  // First member sits in the highest bits, so the fields are listed from the top down.
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] bad_ctrl_count;
    logic [31:0] bad_addr_count;
    logic [31:0] bad_fcs_count;
    logic [31:0] error_count;
    logic [31:0] packet_count;
    logic [31:0] octet_count;
    logic        addr_ctrl_present;
    logic        proto_compressed;
    logic [12:0] payload_length;
    logic [2:0]  payload_start;
    logic [15:0] protocol;
    status_e     status;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/pprc_out_skid.sv @@
module pprc_out_skid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  pprc_pkg::result_t             push_data_i,
  output logic                          ready_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pprc_pkg::RES_W-1:0]    m_axis_tdata
);
  import pprc_pkg::*;

  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    pop;

  assign pop           = out_valid_q && m_axis_tready;
  assign ready_o       = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end else begin
      out_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_q <= push_data_i;
      end
    end else if (push_i) begin
      out_q <= push_data_i;
    end
  end

endmodule

@@ hdl/ppp_frame_receive_checker.sv @@
// Checks received PPP frames in HDLC-like framing. Each request on the slave side carries one
// unescaped frame byte, with tlast on the last byte; one result request leaves for each frame,
// carrying the verdict, the decoded protocol, the payload position and length, and the running
// link-quality counters after that frame. A byte is taken in every cycle: the FCS-16 update,
// header capture and frame verdict are all worked out combinationally between the running frame
// registers and the two-entry result buffer, so the input stalls only when both result entries
// are waiting on the master side. Configuration is sampled at the last byte of each frame and
// should be written only between frames.
module ppp_frame_receive_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pprc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pprc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // data_byte
  input  logic                              s_axis_tlast,  // frame_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status, protocol, payload_start, payload_length, proto_compressed, addr_ctrl_present,
  // octet_count, packet_count, error_count, bad_fcs_count, bad_addr_count, bad_ctrl_count
  output logic [pprc_pkg::RES_W-1:0]        m_axis_tdata
);
  import pprc_pkg::*;

  logic             sync_mode_q;
  logic             accept_acfc_q;
  logic [15:0]      crc_q;
  logic [CNT_W-1:0] count_q;
  logic [7:0]       head_q [4];
  logic [31:0]      octets_q;
  logic [31:0]      packets_q;
  logic [31:0]      errors_q;
  logic [31:0]      fcs_err_q;
  logic [31:0]      addr_err_q;
  logic [31:0]      ctrl_err_q;

  logic             accept;
  logic [15:0]      crc_upd;
  logic [CNT_W-1:0] count_upd;
  logic [7:0]       head_upd [4];
  logic [CNT_W-1:0] len_net;
  logic             hdr_two;
  logic [7:0]       first;
  logic [7:0]       second;
  logic [CNT_W-1:0] need;
  logic             inc_pkt;
  logic             inc_fcs;
  logic             inc_addr;
  logic             inc_ctrl;
  result_t          res;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    crc_upd  = crc_byte(crc_q, s_axis_tdata);
    head_upd = head_q;
    if (count_q < CNT_W'(4)) begin
      head_upd[count_q[1:0]] = s_axis_tdata;
    end
    count_upd = (count_q <= MAX_FRAME_C) ? count_q + CNT_W'(1) : count_q;

    if (sync_mode_q) begin
      len_net = count_upd;
    end else begin
      len_net = (count_upd >= CNT_W'(2)) ? count_upd - CNT_W'(2) : '0;
    end

    hdr_two = (head_upd[0] == ADDR_BYTE) && (head_upd[1] == CTRL_BYTE);
    first   = hdr_two ? head_upd[2] : head_upd[0];
    second  = hdr_two ? head_upd[3] : head_upd[1];
    need    = (hdr_two ? CNT_W'(2) : CNT_W'(0)) + (first[0] ? CNT_W'(1) : CNT_W'(2));

    inc_pkt  = 1'b0;
    inc_fcs  = 1'b0;
    inc_addr = 1'b0;
    inc_ctrl = 1'b0;
    res      = '0;

    if (count_upd > MAX_FRAME_C) begin
      res.status = STATUS_OVERSIZE;
    end else if (!sync_mode_q && crc_upd != FCS_GOOD) begin
      res.status = STATUS_BAD_FCS;
      inc_fcs    = 1'b1;
    end else if (len_net < CNT_W'(2)) begin
      res.status = STATUS_TOO_SHORT;
    end else if (!accept_acfc_q && head_upd[0] != ADDR_BYTE) begin
      res.status = STATUS_BAD_ADDR;
      inc_addr   = 1'b1;
    end else if (!accept_acfc_q && head_upd[1] != CTRL_BYTE) begin
      res.status = STATUS_BAD_CTRL;
      inc_ctrl   = 1'b1;
    end else if (len_net < need) begin
      res.status = STATUS_TOO_SHORT;
    end else begin
      res.status            = STATUS_OK;
      res.protocol          = first[0] ? {8'h00, first} : {first, second};
      res.payload_start     = need[2:0];
      res.payload_length    = 13'(len_net - need);
      res.proto_compressed  = first[0];
      res.addr_ctrl_present = hdr_two;
      inc_pkt               = 1'b1;
    end

    res.octet_count    = octets_q + 32'(count_upd) + 32'd1;
    res.packet_count   = packets_q + 32'(inc_pkt);
    res.error_count    = errors_q + 32'(inc_fcs | inc_addr | inc_ctrl);
    res.bad_fcs_count  = fcs_err_q + 32'(inc_fcs);
    res.bad_addr_count = addr_err_q + 32'(inc_addr);
    res.bad_ctrl_count = ctrl_err_q + 32'(inc_ctrl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_mode_q   <= 1'b0;
      accept_acfc_q <= 1'b0;
      crc_q         <= FCS_INIT;
      count_q       <= '0;
      head_q        <= '{default: '0};
      octets_q      <= '0;
      packets_q     <= '0;
      errors_q      <= '0;
      fcs_err_q     <= '0;
      addr_err_q    <= '0;
      ctrl_err_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_MODE:   sync_mode_q <= cfg_data_i[0];
          CFG_ACCEPT_ACFC: accept_acfc_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (s_axis_tlast) begin
          crc_q      <= FCS_INIT;
          count_q    <= '0;
          head_q     <= '{default: '0};
          octets_q   <= res.octet_count;
          packets_q  <= res.packet_count;
          errors_q   <= res.error_count;
          fcs_err_q  <= res.bad_fcs_count;
          addr_err_q <= res.bad_addr_count;
          ctrl_err_q <= res.bad_ctrl_count;
        end else begin
          crc_q   <= crc_upd;
          count_q <= count_upd;
          head_q  <= head_upd;
        end
      end
    end
  end

  pprc_out_skid u_out_skid (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (accept && s_axis_tlast),
    .push_data_i   (res),
    .ready_o       (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ verif/tb.sv @@
module tb;
  import pprc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_octet_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;  // data_byte
  logic                  s_axis_tlast = 1'b0;   // frame_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RES_W-1:0]      m_axis_tdata;          // fields as listed in result_t

  ppp_frame_receive_checker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2400000;
    $display("end of test: mismatches");
    $finish;
  end

  // Shadow copy of the receiver: configuration, frame accumulators and link counters.
  logic        cfg_sync = 1'b0;
  logic        cfg_acfc = 1'b0;
  logic [15:0] crc_acc = FCS_INIT;
  int unsigned frame_len = 0;
  logic [7:0]  head [4] = '{default: 8'h00};
  logic [31:0] octets = '0;
  logic [31:0] packets = '0;
  logic [31:0] errors = '0;
  logic [31:0] fcs_bad = '0;
  logic [31:0] addr_bad = '0;
  logic [31:0] ctrl_bad = '0;

  result_t     verdicts_due[$];
  rx_octet_t   pending_bytes[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches = 0;

  function automatic logic [15:0] fcs16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[15:1]};
      if (fb) c = c ^ FCS_POLY;
    end
    return c;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    result_t     v;
    int unsigned len;
    int unsigned hdr;
    int unsigned pfl;
    logic [7:0]  lead;
    crc_acc = fcs16_step(crc_acc, b);
    if (frame_len < 4) head[frame_len] = b;
    if (frame_len <= MAX_FRAME) frame_len++;
    if (last) begin
      v = '0;
      len = frame_len;
      octets = octets + 32'(len + 1);
      if (len > MAX_FRAME) begin
        v.status = STATUS_OVERSIZE;
      end else if (!cfg_sync && crc_acc != FCS_GOOD) begin
        v.status = STATUS_BAD_FCS;
        errors++;
        fcs_bad++;
      end else begin
        if (!cfg_sync) len = (len >= 2) ? len - 2 : 0;
        if (len < 2) begin
          v.status = STATUS_TOO_SHORT;
        end else begin
          hdr = 0;
          if (!cfg_acfc) begin
            if (head[0] != ADDR_BYTE) begin
              v.status = STATUS_BAD_ADDR;
              errors++;
              addr_bad++;
            end else if (head[1] != CTRL_BYTE) begin
              v.status = STATUS_BAD_CTRL;
              errors++;
              ctrl_bad++;
            end else begin
              hdr = 2;
            end
          end else if (head[0] == ADDR_BYTE && head[1] == CTRL_BYTE) begin
            hdr = 2;
          end
          if (v.status == STATUS_OK) begin
            lead = head[hdr];
            pfl = lead[0] ? 1 : 2;
            if (len < hdr + pfl) begin
              v.status = STATUS_TOO_SHORT;
            end else begin
              v.protocol = (pfl == 1) ? {8'h00, lead} : {lead, head[hdr + 1]};
              v.payload_start = 3'(hdr + pfl);
              v.payload_length = 13'(len - hdr - pfl);
              v.proto_compressed = (pfl == 1);
              v.addr_ctrl_present = (hdr == 2);
              packets++;
            end
          end
        end
      end
      v.octet_count = octets;
      v.packet_count = packets;
      v.error_count = errors;
      v.bad_fcs_count = fcs_bad;
      v.bad_addr_count = addr_bad;
      v.bad_ctrl_count = ctrl_bad;
      verdicts_due.push_back(v);
      crc_acc = FCS_INIT;
      frame_len = 0;
      foreach (head[i]) head[i] = 8'h00;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10) $display("mismatch in %s: expected %0h, got %0h", what, want, got);
      mismatches++;
    end
  endtask

  result_t got_res;
  result_t want_res;
  logic    byte_taken = 1'b0;

  always @(posedge clk_i) begin
    byte_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      absorb_byte(s_axis_tdata, s_axis_tlast);
      bytes_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = result_t'(m_axis_tdata);
      if (verdicts_due.size() == 0) begin
        if (mismatches < 10) $display("result request with none expected: %0h", m_axis_tdata);
        mismatches++;
      end else begin
        want_res = verdicts_due.pop_front();
        check_field("status", 32'(want_res.status), 32'(got_res.status));
        check_field("protocol", 32'(want_res.protocol), 32'(got_res.protocol));
        check_field("payload_start", 32'(want_res.payload_start), 32'(got_res.payload_start));
        check_field("payload_length", 32'(want_res.payload_length),
                    32'(got_res.payload_length));
        check_field("proto_compressed", 32'(want_res.proto_compressed),
                    32'(got_res.proto_compressed));
        check_field("addr_ctrl_present", 32'(want_res.addr_ctrl_present),
                    32'(got_res.addr_ctrl_present));
        check_field("octet_count", want_res.octet_count, got_res.octet_count);
        check_field("packet_count", want_res.packet_count, got_res.packet_count);
        check_field("error_count", want_res.error_count, got_res.error_count);
        check_field("bad_fcs_count", want_res.bad_fcs_count, got_res.bad_fcs_count);
        check_field("bad_addr_count", want_res.bad_addr_count, got_res.bad_addr_count);
        check_field("bad_ctrl_count", want_res.bad_ctrl_count, got_res.bad_ctrl_count);
      end
    end
  end

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  rx_octet_t   drive_next;

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || byte_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        drive_next = pending_bytes.pop_front();
        s_axis_tdata <= drive_next.data;
        s_axis_tlast <= drive_next.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned stall_timer = 0;
  int unsigned stall_mode = 0;
  logic [7:0]  stall_tick = '0;

  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_done < 2 && bytes_accepted >= ((holds_done == 0) ? 250 : 1400)) begin
      hold_left <= 300;
      holds_done <= holds_done + 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_timer <= $urandom_range(16, 96);
      end else begin
        stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_axis_tready <= stall_tick[2];
        end
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SYNC_MODE) cfg_sync = val;
    else cfg_acfc = val;
  endtask

  task automatic queue_frame(input logic [7:0] body[$], input logic with_fcs,
                             input logic [15:0] fcs_flip);
    logic [15:0] c;
    rx_octet_t   o;
    c = FCS_INIT;
    foreach (body[i]) c = fcs16_step(c, body[i]);
    c = ~c ^ fcs_flip;
    if (with_fcs) begin
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
    end
    foreach (body[i]) begin
      o.data = body[i];
      o.last = (i == body.size() - 1);
      pending_bytes.push_back(o);
    end
    bytes_queued += body.size();
  endtask

  task automatic random_frame();
    logic [7:0]  body[$];
    int unsigned pick;
    int unsigned n;
    logic [7:0]  addr;
    logic [7:0]  ctrl;
    logic [15:0] flip;
    pick = $urandom_range(0, 99);
    flip = 16'h0000;
    if (pick < 85) begin
      addr = ADDR_BYTE;
      ctrl = CTRL_BYTE;
      if (pick < 5) addr = 8'($urandom_range(0, 254));
      else if (pick < 10) ctrl = 8'($urandom_range(0, 255)) ^ ((pick & 1) ? 8'h00 : 8'h80);
      if (ctrl == CTRL_BYTE && pick >= 5 && pick < 10) ctrl = ctrl ^ 8'h01;
      if (!cfg_acfc || $urandom_range(0, 1)) begin
        body.push_back(addr);
        body.push_back(ctrl);
      end
      if ($urandom_range(0, 1)) begin
        body.push_back({7'($urandom), 1'b1});
      end else begin
        body.push_back({7'($urandom), 1'b0});
        body.push_back(8'($urandom));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      repeat (n) body.push_back(8'($urandom));
      if (pick >= 75) begin
        if (!cfg_sync) flip = 16'($urandom_range(1, 65535));
        else while (body.size() > 1 + $urandom_range(0, 2)) void'(body.pop_back());
      end
      queue_frame(body, !cfg_sync, flip);
    end else if (pick < 93) begin
      n = $urandom_range(cfg_sync ? 1 : 0, 3);
      repeat (n) body.push_back(8'($urandom));
      queue_frame(body, !cfg_sync, flip);
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) body.push_back(8'($urandom));
      queue_frame(body, 1'b0, flip);
    end
  endtask

  task automatic fill_random(input int unsigned quota);
    int unsigned base;
    base = bytes_queued;
    while (bytes_queued - base < quota) random_frame();
  endtask

  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || verdicts_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] f[$];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_reg(CFG_SYNC_MODE, 1'b0);
    write_reg(CFG_ACCEPT_ACFC, 1'b0);

    f = {ADDR_BYTE, CTRL_BYTE, 8'h00, 8'h21};
    queue_frame(f, 1'b1, 16'h0000);
    f = {ADDR_BYTE, CTRL_BYTE, 8'hc0, 8'h21};
    queue_frame(f, 1'b1, 16'h8001);
    f = {};
    queue_frame(f, 1'b1, 16'h0000);
    f = {8'h00, CTRL_BYTE, 8'h21};
    queue_frame(f, 1'b1, 16'h0000);
    f = {ADDR_BYTE, 8'h7e, 8'h21};
    queue_frame(f, 1'b1, 16'h0000);
    f = {ADDR_BYTE, CTRL_BYTE, 8'h02};
    queue_frame(f, 1'b1, 16'h0000);
    fill_random(400);
    wait_drained();

    write_reg(CFG_SYNC_MODE, 1'b1);
    write_reg(CFG_ACCEPT_ACFC, 1'b0);
    fill_random(400);
    wait_drained();

    write_reg(CFG_SYNC_MODE, 1'b0);
    write_reg(CFG_ACCEPT_ACFC, 1'b1);
    fill_random(400);
    wait_drained();

    write_reg(CFG_SYNC_MODE, 1'b1);
    write_reg(CFG_ACCEPT_ACFC, 1'b1);
    fill_random(400);
    wait_drained();

    write_reg(CFG_SYNC_MODE, 1'b0);
    write_reg(CFG_ACCEPT_ACFC, 1'b0);
    fill_random(300);
    wait_drained();

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pprc_pkg.sv
hdl/pprc_out_skid.sv
hdl/ppp_frame_receive_checker.sv
verif/tb.sv
